@@ hdl/tba_pkg.sv @@
// Shared types, codes and constants of the trace baseline averager.
package tba_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int SAMPLES_DEF  = 256;
    localparam int NUM_W        = 48;
    localparam int Q_W          = 32;
    localparam int DIV_W        = 17;
    localparam int DIV_STEPS    = 32;

    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    typedef enum logic {OP_UPDATE = 1'b0, OP_RESTART = 1'b1} opcode_t;
    typedef enum logic {MODE_MEAN = 1'b0, MODE_EMA = 1'b1} mode_t;
    typedef enum logic {CFG_UPDATE_MODE = 1'b0, CFG_EMA_WEIGHT = 1'b1} cfg_index_t;
    typedef enum logic [1:0] {KIND_MEAN, KIND_EMA, KIND_KEEP, KIND_NONE} kind_t;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         channel;
        logic [7:0]         sample_index;
        logic signed [31:0] sample_value;
        logic               last_of_trace;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         out_channel;
        logic [7:0]         out_index;
        logic signed [31:0] baseline_value;
        logic [15:0]        traces_averaged;
        logic               out_last;
    } out_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         channel;
        logic [7:0]         index;
        logic               last;
        logic [15:0]        count;
        logic signed [31:0] val;
    } meta_t;

endpackage

@@ hdl/tba_stream_if.sv @@
// Valid/ready stream interface that carries one payload per transaction.
interface tba_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/tba_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with entry tracking.
module tba_div_pipe #(
    parameter int ADDR_W = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [ADDR_W-1:0]      in_addr,
    input  tba_pkg::meta_t         in_meta,
    input  logic [tba_pkg::NUM_W-1:0] in_mag,
    input  logic [tba_pkg::DIV_W-1:0] in_div,
    input  logic                   in_neg,
    input  logic [ADDR_W-1:0]      query_addr,
    output logic                   hit,
    output logic                   out_valid,
    output logic [ADDR_W-1:0]      out_addr,
    output tba_pkg::meta_t         out_meta,
    output logic [tba_pkg::Q_W-1:0] out_q,
    output logic                   out_neg
);
    import tba_pkg::*;

    localparam int REM_W = DIV_W - 1;

    logic              v_reg    [DIV_STEPS+1];
    logic [ADDR_W-1:0] addr_reg [DIV_STEPS+1];
    meta_t             meta_reg [DIV_STEPS+1];
    logic [REM_W-1:0]  rem_reg  [DIV_STEPS+1];
    logic [Q_W-1:0]    wq_reg   [DIV_STEPS+1];
    logic [DIV_W-1:0]  d_reg    [DIV_STEPS+1];
    logic              neg_reg  [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_reg[0] <= in_addr;
            meta_reg[0] <= in_meta;
            rem_reg[0]  <= in_mag[NUM_W-1:Q_W];
            wq_reg[0]   <= in_mag[Q_W-1:0];
            d_reg[0]    <= in_div;
            neg_reg[0]  <= in_neg;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [DIV_W-1:0] trial;
        logic [DIV_W-1:0] diff;
        logic             ge;

        assign trial = {rem_reg[k-1], wq_reg[k-1][Q_W-1]};
        assign ge    = trial >= d_reg[k-1];
        assign diff  = trial - d_reg[k-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                addr_reg[k] <= addr_reg[k-1];
                meta_reg[k] <= meta_reg[k-1];
                rem_reg[k]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                wq_reg[k]   <= {wq_reg[k-1][Q_W-2:0], ge};
                d_reg[k]    <= d_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k <= DIV_STEPS; k++)
        begin
            if (v_reg[k] && meta_reg[k].kind != KIND_NONE && addr_reg[k] == query_addr)
            begin
                hit = 1'b1;
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS];
    assign out_addr  = addr_reg[DIV_STEPS];
    assign out_meta  = meta_reg[DIV_STEPS];
    assign out_q     = wq_reg[DIV_STEPS];
    assign out_neg   = neg_reg[DIV_STEPS];

endmodule

@@ hdl/trace_baseline_averager.sv @@
// Top level: per-channel baseline trace kept by running mean or moving average.
// Accepted samples pass stages a, b, c, the 32-stage divider and the output register;
// one sample per cycle while results are taken, no clearing runs and no entry hazard holds.
// A sample to an entry still in flight waits until its result is written back to the store.
// After reset a clearing pass zeroes the store, one entry at a time, while no sample is taken;
// counts and registers clear at once.
module trace_baseline_averager #(
    parameter int CHANNELS          = tba_pkg::CHANNELS_DEF,
    parameter int SAMPLES_PER_TRACE = tba_pkg::SAMPLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tba_stream_if.sink  samples,
    tba_stream_if.source results,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);
    import tba_pkg::*;

    localparam int DEPTH  = CHANNELS * SAMPLES_PER_TRACE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [31:0] mem [DEPTH];

    mode_t       mode_reg;
    logic [16:0] weight_reg;
    logic [15:0] count_reg [CHANNELS];
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_reg;

    in_item_t          item;
    logic              accept;
    logic              en;
    logic              in_range;
    logic [CH_W-1:0]   cidx;
    logic [ADDR_W-1:0] addr_in;
    logic [15:0]       n_cur;
    logic [15:0]       n_after;
    kind_t             kind_in;
    logic              hit_div;
    logic              hit_any;

    logic               a_v_reg;
    meta_t              a_meta_reg;
    logic [ADDR_W-1:0]  a_addr_reg;
    logic signed [31:0] a_x_reg;
    logic [15:0]        a_n_reg;
    logic [16:0]        a_w_reg;
    logic signed [31:0] rd_data_reg;

    logic               b_v_reg;
    meta_t              b_meta_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic signed [31:0] b_old_reg;
    logic signed [31:0] b_x_reg;
    logic signed [32:0] b_diff_reg;
    logic [15:0]        b_n_reg;
    logic [16:0]        b_w_reg;

    logic               c_v_reg;
    meta_t              c_meta_reg;
    logic [ADDR_W-1:0]  c_addr_reg;
    logic signed [31:0] c_old_reg;
    logic signed [31:0] c_x_reg;
    logic [15:0]        c_n_reg;
    logic signed [48:0] c_mprod_reg;
    logic signed [50:0] c_eprod_reg;

    logic signed [49:0] num;
    logic signed [49:0] num_abs;
    logic [NUM_W-1:0]   div_mag;
    logic [DIV_W-1:0]   div_d;
    logic signed [50:0] e_adj;
    logic signed [50:0] e_q;
    logic signed [31:0] ema_val;
    meta_t              d_meta;

    logic               dv;
    logic [ADDR_W-1:0]  d_addr;
    meta_t              dm;
    logic [Q_W-1:0]     dq;
    logic               dneg;
    logic signed [31:0] final_val;
    logic               wr_pipe;

    logic      out_v_reg;
    out_item_t out_reg;

    assign item     = samples.data;
    assign en       = !out_v_reg || results.ready;
    assign in_range = (32'(item.channel) < CHANNELS) && (32'(item.sample_index) < SAMPLES_PER_TRACE);
    assign cidx     = CH_W'(item.channel);
    assign addr_in  = in_range ? (ADDR_W'(item.channel) * ADDR_W'(SAMPLES_PER_TRACE)
                                  + ADDR_W'(item.sample_index)) : '0;
    assign n_cur    = in_range ? count_reg[cidx] : 16'd0;

    always_comb
    begin
        priority if (!in_range)
        begin
            kind_in = KIND_NONE;
        end
        else if (opcode_t'(item.opcode) == OP_RESTART)
        begin
            kind_in = KIND_KEEP;
        end
        else if (mode_reg == MODE_EMA)
        begin
            kind_in = KIND_EMA;
        end
        else
        begin
            kind_in = KIND_MEAN;
        end
        unique case (kind_in)
            KIND_MEAN: n_after = (item.last_of_trace && n_cur != COUNT_MAX) ? n_cur + 16'd1 : n_cur;
            KIND_EMA:  n_after = n_cur;
            default:   n_after = 16'd0;
        endcase
    end

    assign hit_any = in_range && (hit_div
        || (a_v_reg && a_meta_reg.kind != KIND_NONE && a_addr_reg == addr_in)
        || (b_v_reg && b_meta_reg.kind != KIND_NONE && b_addr_reg == addr_in)
        || (c_v_reg && c_meta_reg.kind != KIND_NONE && c_addr_reg == addr_in));

    assign samples.ready = en && !clearing_reg && !hit_any;
    assign accept        = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_MEAN;
            weight_reg   <= 17'd0;
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                count_reg[i] <= 16'd0;
            end
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_UPDATE_MODE: mode_reg   <= mode_t'(cfg_data[0]);
                    CFG_EMA_WEIGHT:  weight_reg <= cfg_data;
                endcase
            end
            if (clearing_reg)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept && kind_in != KIND_NONE)
            begin
                count_reg[cidx] <= n_after;
            end
            if (en)
            begin
                a_v_reg   <= accept;
                b_v_reg   <= a_v_reg;
                c_v_reg   <= b_v_reg;
                out_v_reg <= dv;
            end
        end
    end

    assign wr_pipe = en && dv && dm.kind != KIND_NONE;

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_reg] <= 32'sd0;
        end
        else if (wr_pipe)
        begin
            mem[d_addr] <= final_val;
        end
        if (accept)
        begin
            rd_data_reg <= mem[addr_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_meta_reg.kind    <= kind_in;
            a_meta_reg.channel <= item.channel;
            a_meta_reg.index   <= item.sample_index;
            a_meta_reg.last    <= item.last_of_trace;
            a_meta_reg.count   <= n_after;
            a_meta_reg.val     <= 32'sd0;
            a_addr_reg <= addr_in;
            a_x_reg    <= item.sample_value;
            a_n_reg    <= n_cur;
            a_w_reg    <= (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;

            b_meta_reg <= a_meta_reg;
            b_addr_reg <= a_addr_reg;
            b_old_reg  <= rd_data_reg;
            b_x_reg    <= a_x_reg;
            b_diff_reg <= 33'(a_x_reg) - 33'(rd_data_reg);
            b_n_reg    <= a_n_reg;
            b_w_reg    <= a_w_reg;

            c_meta_reg  <= b_meta_reg;
            c_addr_reg  <= b_addr_reg;
            c_old_reg   <= b_old_reg;
            c_x_reg     <= b_x_reg;
            c_n_reg     <= b_n_reg;
            c_mprod_reg <= $signed({1'b0, b_n_reg}) * b_old_reg;
            c_eprod_reg <= $signed({1'b0, b_w_reg}) * b_diff_reg;

            out_reg.out_channel     <= dm.channel;
            out_reg.out_index       <= dm.index;
            out_reg.baseline_value  <= final_val;
            out_reg.traces_averaged <= dm.count;
            out_reg.out_last        <= dm.last;
        end
    end

    always_comb
    begin
        num     = 50'(c_mprod_reg) + 50'(c_x_reg);
        num_abs = num[49] ? -num : num;
        div_mag = num_abs[NUM_W-1:0];
        div_d   = {1'b0, c_n_reg} + DIV_W'(1);
        e_adj   = c_eprod_reg + (c_eprod_reg[50] ? 51'sd65535 : 51'sd0);
        e_q     = e_adj >>> 16;
        ema_val = c_old_reg + e_q[31:0];
        d_meta  = c_meta_reg;
        unique case (c_meta_reg.kind)
            KIND_EMA:  d_meta.val = ema_val;
            KIND_KEEP: d_meta.val = c_old_reg;
            default:   d_meta.val = 32'sd0;
        endcase
    end

    tba_div_pipe #(
        .ADDR_W (ADDR_W)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (c_v_reg),
        .in_addr    (c_addr_reg),
        .in_meta    (d_meta),
        .in_mag     (div_mag),
        .in_div     (div_d),
        .in_neg     (num[49]),
        .query_addr (addr_in),
        .hit        (hit_div),
        .out_valid  (dv),
        .out_addr   (d_addr),
        .out_meta   (dm),
        .out_q      (dq),
        .out_neg    (dneg)
    );

    always_comb
    begin
        unique case (dm.kind)
            KIND_MEAN: final_val = dneg ? -$signed(dq) : $signed(dq);
            default:   final_val = dm.val;
        endcase
    end

    assign results.valid = out_v_reg;
    assign results.data  = out_reg;

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !clearing_reg)
        else $error("Sample transaction accepted during the clearing pass.");

    a_no_write_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !(dv || c_v_reg || b_v_reg || a_v_reg))
        else $error("Pipeline holds work while the store is being cleared.");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |=> !clearing_reg)
        else $error("Clearing pass restarted without reset.");

endmodule

@@ verif/tba_scoreboard.sv @@
// Checker that predicts each baseline update and compares it with the block's output.
module tba_scoreboard
    import tba_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tba_stream_if.sink   mon_in,
    tba_stream_if.sink   mon_out,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [16:0]  cfg_data,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] baseline_mem [16][256];
    logic [15:0]        chan_count [16];
    mode_t              cur_mode;
    logic [16:0]        cur_weight;
    out_item_t          expected_q [$];

    function automatic out_item_t baseline_predict(in_item_t it);
        out_item_t r;
        logic signed [31:0] old_v;
        longint n;
        longint num;
        longint wt;
        old_v = baseline_mem[it.channel][it.sample_index];
        n = chan_count[it.channel];
        if (opcode_t'(it.opcode) == OP_RESTART)
        begin
            chan_count[it.channel] = 16'd0;
        end
        else if (cur_mode == MODE_MEAN)
        begin
            num = n * longint'(old_v) + longint'(it.sample_value);
            baseline_mem[it.channel][it.sample_index] = 32'(num / (n + 1));
            if (it.last_of_trace && chan_count[it.channel] != COUNT_MAX)
            begin
                chan_count[it.channel] = chan_count[it.channel] + 16'd1;
            end
        end
        else
        begin
            wt = (cur_weight > WEIGHT_ONE) ? 65536 : longint'(cur_weight);
            num = wt * (longint'(it.sample_value) - longint'(old_v));
            baseline_mem[it.channel][it.sample_index] = 32'(longint'(old_v) + num / 65536);
        end
        r.out_channel     = it.channel;
        r.out_index       = it.sample_index;
        r.baseline_value  = baseline_mem[it.channel][it.sample_index];
        r.traces_averaged = chan_count[it.channel];
        r.out_last        = it.last_of_trace;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        out_item_t a;
        if (!rst_n)
        begin
            foreach (baseline_mem[c, i]) baseline_mem[c][i] = 32'sd0;
            foreach (chan_count[c]) chan_count[c] = 16'd0;
            cur_mode   = MODE_MEAN;
            cur_weight = 17'd0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index_t'(cfg_index) == CFG_UPDATE_MODE)
                    cur_mode = mode_t'(cfg_data[0]);
                else
                    cur_weight = cfg_data;
            end
            if (mon_in.valid && mon_in.ready)
                expected_q.push_back(baseline_predict(mon_in.data));
            if (mon_out.valid && mon_out.ready)
            begin
                a = mon_out.data;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction %p", a);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e !== a)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result differs: expected %p actual %p", e, a);
                    end
                end
            end
        end
        pending = expected_q.size();
    end
endmodule

@@ verif/tb_trace_baseline_averager.sv @@
// Testbench top: stimulus, configuration phases, handshake pressure and verdict.
module tb_trace_baseline_averager;
    import tba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    tba_stream_if #(in_item_t)  samples ();
    tba_stream_if #(out_item_t) results ();

    trace_baseline_averager u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples.sink),
        .results   (results.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tba_scoreboard u_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .mon_in     (samples.sink),
        .mon_out    (results.sink),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("trace_baseline_averager: mismatch");
        $finish;
    end

    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_sample(input in_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid <= 1'b1;
        samples.data  <= it;
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [16:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        samples.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic in_item_t make_sample(logic op, logic [3:0] ch, logic [7:0] idx,
                                             logic [31:0] v, logic last);
        in_item_t it;
        it.opcode        = op;
        it.channel       = ch;
        it.sample_index  = idx;
        it.sample_value  = v;
        it.last_of_trace = last;
        return it;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($urandom_range(200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_traces(input int n_items);
        int sent;
        int len;
        logic [3:0] ch;
        logic [7:0] base;
        sent = 0;
        while (sent < n_items)
        begin
            ch   = 4'($urandom_range(15));
            base = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(7));
            len  = $urandom_range(1, 8);
            if ($urandom_range(9) == 0)
            begin
                send_sample(make_sample(OP_RESTART, ch, 8'($urandom), $urandom,
                                        1'($urandom)));
                sent++;
            end
            for (int i = 0; i < len; i++)
            begin
                send_sample(make_sample(OP_UPDATE, ch, base + 8'(i), random_value(),
                                        (i == len - 1) ? ($urandom_range(7) != 0)
                                                       : ($urandom_range(15) == 0)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_UPDATE_MODE;
        cfg_data       = 17'd0;
        samples.valid  = 1'b0;
        samples.data   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_sample(make_sample(OP_UPDATE, 4'd0, 8'd0, 32'h7FFFFFFF, 1'b1));
        send_sample(make_sample(OP_UPDATE, 4'd0, 8'd0, 32'h80000000, 1'b1));
        send_sample(make_sample(OP_UPDATE, 4'd0, 8'd0, 32'h80000000, 1'b0));
        send_sample(make_sample(OP_UPDATE, 4'd15, 8'd255, 32'hFFFFFFFF, 1'b1));
        send_sample(make_sample(OP_UPDATE, 4'd15, 8'd255, 32'h00000002, 1'b1));
        send_sample(make_sample(OP_UPDATE, 4'd15, 8'd255, 32'hFFFFFFFC, 1'b0));
        send_sample(make_sample(OP_RESTART, 4'd15, 8'd255, 32'h12345678, 1'b1));
        send_sample(make_sample(OP_UPDATE, 4'd15, 8'd255, 32'h00000007, 1'b1));
        send_sample(make_sample(OP_RESTART, 4'd0, 8'd3, 32'h0, 1'b0));
        drain_results();

        write_reg(CFG_UPDATE_MODE, 17'(MODE_EMA));
        write_reg(CFG_EMA_WEIGHT, 17'h1FFFF);
        send_sample(make_sample(OP_UPDATE, 4'd3, 8'd7, 32'h80000000, 1'b1));
        send_sample(make_sample(OP_UPDATE, 4'd3, 8'd7, 32'h7FFFFFFF, 1'b0));
        drain_results();
        write_reg(CFG_EMA_WEIGHT, 17'h10000);
        send_sample(make_sample(OP_UPDATE, 4'd3, 8'd7, 32'h80000000, 1'b0));
        drain_results();
        write_reg(CFG_EMA_WEIGHT, 17'd1);
        send_sample(make_sample(OP_UPDATE, 4'd3, 8'd7, 32'h7FFFFFFF, 1'b0));
        send_sample(make_sample(OP_UPDATE, 4'd3, 8'd7, 32'hFFFFFFFF, 1'b1));
        drain_results();
        write_reg(CFG_EMA_WEIGHT, 17'd0);
        send_sample(make_sample(OP_UPDATE, 4'd3, 8'd7, 32'h11111111, 1'b0));
        drain_results();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(CFG_UPDATE_MODE, 17'(phase % 2));
            write_reg(CFG_EMA_WEIGHT, (phase == 3) ? 17'h10000 : 17'($urandom));
            send_idle_pct  = (phase % 4 == 1 || phase % 4 == 3) ? (phase % 4 == 3 ? 21 : 63) : 0;
            recv_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? (phase % 4 == 3 ? 21 : 63) : 0;
            if (phase == 2)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_traces(225);
            drain_results();
        end
        hold_off = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();

        if (fail_count == 0)
            $display("trace_baseline_averager: match");
        else
            $display("trace_baseline_averager: mismatch");
        $finish;
    end
endmodule
